FILE: design/rcfd_pkg.sv
// Shared types and constants for the RC satellite frame decoder.
// No dependencies; imported by rcfd_stage_mem, rc_satellite_frame_decoder, rcfd_channel_checker and tb.
package rcfd_pkg;

    localparam int IDX_W   = 4;
    localparam int VALUE_W = 11;

    localparam logic [1:0] CFG_FRAME_GAP  = 2'd0;
    localparam logic [1:0] CFG_LOSS_LIMIT = 2'd1;
    localparam logic [1:0] CFG_THR_FLOOR  = 2'd2;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [7:0] SYNC_10B_A = 8'h01;
    localparam logic [7:0] SYNC_10B_B = 8'hb2;
    localparam logic [7:0] SYNC_10B_C = 8'h02;
    localparam logic [7:0] SYNC_11B   = 8'h12;

    localparam logic [4:0] MODE_POS   = 5'd2;
    localparam logic [4:0] FRAME_LEN  = 5'd16;

    localparam logic [2:0] GAP_RESET    = 3'd4;
    localparam logic [4:0] LOSS_RESET   = 5'd30;
    localparam logic [10:0] FLOOR_RESET = 11'd10;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD   = 4'b0010,
        ST_LOAD = 4'b0100,
        ST_SEND = 4'b1000
    } emit_state_t;

    // Command bundle from the frame logic to the staging store
    typedef struct packed {
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        logic [VALUE_W-1:0] wr_data;
        logic               clear;
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
    } stage_cmd_t;

endpackage

FILE: design/rcfd_stage_mem.sv
// Channel staging store: synchronous memory with registered read.
// Per-entry valid bits make unwritten or cleared entries read as zero.
// Depends on rcfd_pkg.
module rcfd_stage_mem #(
    parameter int DEPTH = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rcfd_pkg::stage_cmd_t        cmd,
    output logic [rcfd_pkg::VALUE_W-1:0] rd_data
);
    import rcfd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.clear) begin
            valid_reg <= '0;
        end else if (cmd.wr_en) begin
            valid_reg[cmd.wr_addr[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= valid_reg[cmd.rd_addr[AW-1:0]] ? mem[cmd.rd_addr[AW-1:0]]
                                                            : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/rc_satellite_frame_decoder.sv
// Usage
//   Input beats (s_*): tuser[0] selects a received byte (0) or a supervisor
//   tick (1); tdata[7:0] carries the byte. Result beats (m_*): one beat per
//   channel, tlast on channel CHANNELS-1, tuser[0] set when the run reports
//   signal loss. Configuration (cfg_*): index 0 frame gap ticks, 1 loss
//   limit, 2 throttle floor; cfg_ready is always high, other indexes drop.
//   Flow: a byte or tick that emits nothing does not hold the input off. A frame
//   end on a good frame, or a signal loss, starts a run of CHANNELS beats;
//   each beat goes through a staging memory read, an output load and the
//   send, so a run holds the input off until its last beat is sent, stalls
//   by the receiver included. The first result beat is valid once the run
//   has passed the read and load states into the output register.
//   Reset: aresetn low for one edge clears the frame state, loads the
//   register defaults and invalidates every staging entry at once (they
//   read as zero); no clearing pass is needed.
//   Stall: while m_tready is low the result beat holds and s_tready stays
//   low until the run is complete.
// Depends on rcfd_pkg and rcfd_stage_mem.
module rc_satellite_frame_decoder #(
    parameter int CHANNELS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic [0:0]  s_tuser,   // [0] operation
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] channel_index, [14:4] channel_value, [15] zero
    output logic [0:0]  m_tuser,   // [0] signal_lost
    output logic        m_tlast,   // last_of_run
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import rcfd_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [AW-1:0] LAST_CH = AW'(CHANNELS - 1);
    localparam logic [IDX_W:0] CH_LIMIT = (IDX_W + 1)'(CHANNELS);

    // configuration
    logic [2:0]  frame_gap_reg;
    logic [4:0]  loss_limit_reg;
    logic [10:0] floor_reg;

    // frame state
    logic        in_sync_reg,   in_sync_next;
    logic [4:0]  pos_reg,       pos_next;
    logic [7:0]  prev_reg,      prev_next;
    logic        eleven_reg,    eleven_next;
    logic        bad_reg,       bad_next;
    logic [2:0]  gap_reg,       gap_next;
    logic [4:0]  resync_reg,    resync_next;

    // run emitter
    emit_state_t state_reg, state_next;
    logic [AW-1:0] ch_reg, ch_next;
    logic        lost_reg, lost_next;

    logic              out_valid_reg;
    logic [AW-1:0]     out_idx_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic              out_lost_reg;
    logic              out_last_reg;

    stage_cmd_t          cmd;
    logic [VALUE_W-1:0]  rd_data;

    logic               accept;
    logic [4:0]         pos_inc;
    logic [15:0]        word;
    logic [IDX_W-1:0]   word_idx;
    logic [VALUE_W-1:0] word_val;
    logic [2:0]         gap_inc;
    logic [4:0]         resync_inc;
    logic               start_run;
    logic               start_lost;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign pos_inc    = pos_reg + 5'd1;
    assign word       = {prev_reg, s_tdata};
    assign word_idx   = eleven_reg ? word[14:11] : word[13:10];
    assign word_val   = eleven_reg ? word[10:0] : {1'b0, word[9:0]};
    assign gap_inc    = gap_reg + 3'd1;
    assign resync_inc = resync_reg + 5'd1;

    always_comb begin
        in_sync_next = in_sync_reg;
        pos_next     = pos_reg;
        prev_next    = prev_reg;
        eleven_next  = eleven_reg;
        bad_next     = bad_reg;
        gap_next     = gap_reg;
        resync_next  = resync_reg;
        start_run    = 1'b0;
        start_lost   = 1'b0;
        cmd          = '0;
        cmd.wr_addr  = word_idx;
        cmd.wr_data  = word_val;

        if (accept) begin
            if (s_tuser[0] == OP_TICK) begin
                gap_next = gap_inc;
                if (gap_inc > frame_gap_reg) begin
                    in_sync_next = 1'b0;
                    pos_next     = '0;
                    prev_next    = 8'hFF;
                    bad_next     = 1'b0;
                    gap_next     = '0;
                    resync_next  = resync_inc;
                    if (resync_inc > loss_limit_reg) begin
                        resync_next = '0;
                        cmd.clear   = 1'b1;
                        start_run   = 1'b1;
                        start_lost  = 1'b1;
                    end
                end
            end else begin
                pos_next = pos_inc;
                if (!in_sync_reg) begin
                    if (pos_inc == MODE_POS) begin
                        if (s_tdata == SYNC_10B_A || s_tdata == SYNC_10B_B ||
                            s_tdata == SYNC_10B_C) begin
                            eleven_next  = 1'b0;
                            in_sync_next = 1'b1;
                        end else if (s_tdata == SYNC_11B) begin
                            eleven_next  = 1'b1;
                            in_sync_next = 1'b1;
                        end else begin
                            pos_next = '0;
                        end
                    end
                end else if (!pos_inc[0]) begin
                    // channel 0 below the floor spoils the rest of the frame
                    if (word_idx == '0 && word_val < floor_reg) begin
                        bad_next = 1'b1;
                    end
                    if ({1'b0, word_idx} < CH_LIMIT && !bad_next) begin
                        cmd.wr_en = 1'b1;
                    end
                end
                if (pos_next == FRAME_LEN) begin
                    pos_next     = '0;
                    in_sync_next = 1'b0;
                    resync_next  = '0;
                    start_run    = !bad_next;
                    bad_next     = 1'b0;
                end
                prev_next = s_tdata;
            end
        end

        // run emitter: read, load, send per channel
        state_next = state_reg;
        ch_next    = ch_reg;
        lost_next  = lost_reg;
        cmd.rd_addr = IDX_W'(ch_reg);
        case (state_reg)
            ST_IDLE: begin
                if (start_run) begin
                    state_next = ST_RD;
                    ch_next    = '0;
                    lost_next  = start_lost;
                end
            end
            ST_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_tready) begin
                    if (ch_reg == LAST_CH) begin
                        state_next = ST_IDLE;
                    end else begin
                        ch_next    = ch_reg + AW'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_gap_reg  <= GAP_RESET;
            loss_limit_reg <= LOSS_RESET;
            floor_reg      <= FLOOR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FRAME_GAP:  frame_gap_reg  <= cfg_data[2:0];
                CFG_LOSS_LIMIT: loss_limit_reg <= cfg_data[4:0];
                CFG_THR_FLOOR:  floor_reg      <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_sync_reg <= 1'b0;
            pos_reg     <= '0;
            prev_reg    <= 8'hFF;
            eleven_reg  <= 1'b0;
            bad_reg     <= 1'b0;
            gap_reg     <= '0;
            resync_reg  <= '0;
            state_reg   <= ST_IDLE;
            ch_reg      <= '0;
            lost_reg    <= 1'b0;
        end else begin
            in_sync_reg <= in_sync_next;
            pos_reg     <= pos_next;
            prev_reg    <= prev_next;
            eleven_reg  <= eleven_next;
            bad_reg     <= bad_next;
            gap_reg     <= gap_next;
            resync_reg  <= resync_next;
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            lost_reg    <= lost_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == ST_LOAD) begin
            out_valid_reg <= 1'b1;
        end else if (m_tvalid && m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD) begin
            out_idx_reg   <= ch_reg;
            out_value_reg <= rd_data;
            out_lost_reg  <= lost_reg;
            out_last_reg  <= (ch_reg == LAST_CH);
        end
    end

    rcfd_stage_mem #(
        .DEPTH(CHANNELS)
    ) u_stage_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rd_data (rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_value_reg, IDX_W'(out_idx_reg)};
    assign m_tuser  = out_lost_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: design/rcfd_checker.sv
// Port-level checker for rc_satellite_frame_decoder, bound to the top level.
// Depends on the top level's ports and its CHANNELS parameter only.
module rcfd_checker #(
    parameter int CHANNELS = 12
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // result beat holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result beat changed while stalled");

    // input is held off while a run is in flight
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready during a run");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[3:0] == 4'(CHANNELS - 1)))
        else $error("run ended on the wrong channel");

    a_lost_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[14:4] == 11'd0))
        else $error("nonzero value in a signal-loss run");

endmodule

bind rc_satellite_frame_decoder rcfd_checker #(
    .CHANNELS(CHANNELS)
) u_rcfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: bench/rcfd_channel_checker.sv
`timescale 1ns / 1ps
// Scoreboard for rc_satellite_frame_decoder: tracks the frame state from the accepted
// input and configuration beats and compares every result beat. Depends on rcfd_pkg.
module rcfd_channel_checker #(
    parameter int CHANNELS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic [0:0]  s_tuser,   // [0] operation
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [3:0] channel_index, [14:4] channel_value, [15] zero
    input  logic [0:0]  m_tuser,   // [0] signal_lost
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          beats_checked
);
    import rcfd_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [VALUE_W-1:0] value;
        logic               lost;
        logic               last;
    } channel_beat_t;

    channel_beat_t expected_channels[$];

    logic [2:0]         gap_limit;
    logic [4:0]         loss_limit;
    logic [VALUE_W-1:0] throttle_floor;

    logic               in_sync;
    logic [4:0]         byte_pos;
    logic [7:0]         last_byte;
    logic               eleven_bit;
    logic               frame_bad;
    logic [2:0]         gap_ticks;
    logic [4:0]         resync_count;
    logic [VALUE_W-1:0] staged [CHANNELS];

    task automatic queue_channel_run(input logic lost);
        channel_beat_t b;
        for (int k = 0; k < CHANNELS; k++) begin
            b.index = IDX_W'(k);
            b.value = lost ? '0 : staged[k];
            b.lost  = lost;
            b.last  = (k == CHANNELS - 1);
            expected_channels.push_back(b);
        end
    endtask

    task automatic decode_beat(input logic op, input logic [7:0] value);
        logic [15:0]        word;
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] ch_value;
        if (op == OP_TICK) begin
            // bytes never clear the gap count, only a resync does
            gap_ticks = gap_ticks + 3'd1;
            if (gap_ticks > gap_limit) begin
                in_sync      = 1'b0;
                byte_pos     = '0;
                last_byte    = 8'hFF;
                frame_bad    = 1'b0;
                gap_ticks    = '0;
                resync_count = resync_count + 5'd1;
                if (resync_count > loss_limit) begin
                    resync_count = '0;
                    foreach (staged[k]) staged[k] = '0;
                    queue_channel_run(1'b1);
                end
            end
        end else begin
            byte_pos = byte_pos + 5'd1;
            if (!in_sync) begin
                if (byte_pos == MODE_POS) begin
                    if (value == SYNC_10B_A || value == SYNC_10B_B || value == SYNC_10B_C) begin
                        eleven_bit = 1'b0;
                        in_sync    = 1'b1;
                    end else if (value == SYNC_11B) begin
                        eleven_bit = 1'b1;
                        in_sync    = 1'b1;
                    end else begin
                        byte_pos = '0;
                    end
                end
            end else if (!byte_pos[0]) begin
                word = {last_byte, value};
                if (eleven_bit) begin
                    idx      = word[14:11];
                    ch_value = word[10:0];
                end else begin
                    idx      = word[13:10];
                    ch_value = {1'b0, word[9:0]};
                end
                // the throttle check on channel 0 comes before the write, so a low value is not staged
                if (idx == 0 && ch_value < throttle_floor)
                    frame_bad = 1'b1;
                if (idx < CHANNELS && !frame_bad)
                    staged[idx] = ch_value;
            end
            if (byte_pos == FRAME_LEN) begin
                byte_pos     = '0;
                in_sync      = 1'b0;
                resync_count = '0;
                if (!frame_bad)
                    queue_channel_run(1'b0);
                frame_bad = 1'b0;
            end
            last_byte = value;
        end
    endtask

    task automatic check_result();
        channel_beat_t want;
        if (expected_channels.size() == 0) begin
            $error("result beat with nothing predicted: channel_index %0d", m_tdata[3:0]);
            fail_count++;
        end else begin
            want = expected_channels.pop_front();
            beats_checked++;
            if (m_tdata[3:0] !== want.index) begin
                $error("channel_index mismatch: expected %0d, got %0d", want.index, m_tdata[3:0]);
                fail_count++;
            end
            if (m_tdata[14:4] !== want.value) begin
                $error("channel_value mismatch: expected %0d, got %0d", want.value, m_tdata[14:4]);
                fail_count++;
            end
            if (m_tuser[0] !== want.lost) begin
                $error("signal_lost mismatch: expected %0d, got %0d", want.lost, m_tuser[0]);
                fail_count++;
            end
            if (m_tlast !== want.last) begin
                $error("last_of_run mismatch: expected %0d, got %0d", want.last, m_tlast);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            gap_limit      = GAP_RESET;
            loss_limit     = LOSS_RESET;
            throttle_floor = FLOOR_RESET;
            in_sync        = 1'b0;
            byte_pos       = '0;
            last_byte      = 8'hFF;
            eleven_bit     = 1'b0;
            frame_bad      = 1'b0;
            gap_ticks      = '0;
            resync_count   = '0;
            foreach (staged[k]) staged[k] = '0;
            expected_channels.delete();
        end else begin
            // a result beat always belongs to an earlier input beat, so check first
            if (m_tvalid && m_tready)
                check_result();
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FRAME_GAP:  gap_limit      = cfg_data[2:0];
                    CFG_LOSS_LIMIT: loss_limit     = cfg_data[4:0];
                    CFG_THR_FLOOR:  throttle_floor = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                decode_beat(s_tuser[0], s_tdata);
        end
        pending <= expected_channels.size();
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Top-level bench for rc_satellite_frame_decoder: clock, reset, byte and tick stimulus,
// register phases and the verdict. Depends on rcfd_pkg, the RTL and rcfd_channel_checker.
module tb;
    import rcfd_pkg::*;

    localparam int         CHANNELS   = 12;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] byte_value
    logic [0:0]  s_tuser   = '0;   // [0] operation
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [3:0] channel_index, [14:4] channel_value, [15] zero
    logic [0:0]  m_tuser;          // [0] signal_lost
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int beats_checked;

    bit quiet         = 1'b0;
    int gap_cfg       = int'(GAP_RESET);
    int floor_cfg     = int'(FLOOR_RESET);
    int gap_mirror    = 0;
    bit resynced      = 1'b0;
    int beats_sent    = 0;
    int frames_sent   = 0;
    int settings_used = 0;

    always #2 aclk = ~aclk;

    rc_satellite_frame_decoder #(
        .CHANNELS (CHANNELS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rcfd_channel_checker #(
        .CHANNELS (CHANNELS)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_checked (beats_checked)
    );

    task automatic send_beat(input logic op, input logic [7:0] value);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        beats_sent++;
        // follow the tick count only to know when the hunt restarts at position zero
        if (op == OP_TICK) begin
            gap_mirror = (gap_mirror + 1) % 8;
            if (gap_mirror > gap_cfg) begin
                gap_mirror = 0;
                resynced   = 1'b1;
            end
        end
    endtask

    task automatic send_channel_word(input logic eleven, input logic [3:0] idx,
                                     input logic [10:0] value);
        logic [15:0] word;
        word = 16'($urandom);
        if (eleven)
            word[14:0] = {idx, value};
        else
            word[13:0] = {idx, value[9:0]};
        send_beat(OP_BYTE, word[15:8]);
        send_beat(OP_BYTE, word[7:0]);
    endtask

    task automatic send_frame(input int n_words, output bit broken);
        logic [7:0]  mode;
        logic        eleven;
        logic [3:0]  idx;
        logic [10:0] value;
        logic [10:0] top;
        case ($urandom_range(0, 8))
            0, 1:    mode = SYNC_10B_A;
            2, 3:    mode = SYNC_10B_B;
            4, 5:    mode = SYNC_10B_C;
            6, 7:    mode = SYNC_11B;
            default: mode = 8'($urandom);
        endcase
        eleven   = (mode == SYNC_11B);
        top      = eleven ? 11'h7FF : 11'h3FF;
        resynced = 1'b0;
        send_beat(OP_BYTE, 8'($urandom));
        send_beat(OP_BYTE, mode);
        for (int k = 0; k < n_words; k++) begin
            if ($urandom_range(0, 24) == 0)
                send_beat(OP_TICK, 8'($urandom));
            if ($urandom_range(0, 9) == 0)
                idx = 4'($urandom_range(CHANNELS, 15));
            else
                idx = 4'($urandom_range(0, CHANNELS - 1));
            value = 11'($urandom_range(0, top));
            // keep most throttle values at or above the floor so most frames commit
            if (idx == 0 && floor_cfg <= top && $urandom_range(0, 5) != 0)
                value = 11'($urandom_range(floor_cfg, top));
            send_channel_word(eleven, idx, value);
        end
        if (n_words == 7)
            frames_sent++;
        broken = resynced || !(eleven || mode == SYNC_10B_A || mode == SYNC_10B_B
                               || mode == SYNC_10B_C);
    endtask

    // Tick until the decoder is back to hunting at frame position zero.
    task automatic force_resync();
        resynced = 1'b0;
        do send_beat(OP_TICK, 8'($urandom)); while (!resynced);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [10:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
    endtask

    task automatic set_config(input int gap, input int loss, input int thr);
        write_reg(CFG_FRAME_GAP, 11'(gap));
        write_reg(CFG_LOSS_LIMIT, 11'(loss));
        write_reg(CFG_THR_FLOOR, 11'(thr));
        cfg_valid <= 1'b0;
        gap_cfg   = gap;
        floor_cfg = thr;
        settings_used++;
    endtask

    task automatic run_traffic(input int n_items, input bit calm);
        int stop_at;
        bit broken;
        stop_at = beats_sent + n_items;
        while (beats_sent < stop_at) begin
            quiet  = calm || ($urandom_range(0, 4) == 0);
            broken = 1'b0;
            case ($urandom_range(0, 10))
                8: begin
                    repeat ($urandom_range(1, 6))
                        send_beat(1'($urandom_range(0, 1)), 8'($urandom));
                    broken = 1'b1;
                end
                9: repeat ($urandom_range(1, 10)) send_beat(OP_TICK, 8'($urandom));
                10: begin
                    send_frame($urandom_range(0, 6), broken);
                    broken = 1'b1;
                end
                default: send_frame(7, broken);
            endcase
            // realign unless ticks can never force a resync
            if (broken && gap_cfg < 7)
                force_resync();
        end
        quiet = 1'b0;
    endtask

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // tick, a rejected mode byte, then an 11-bit frame with extreme values
        send_beat(OP_TICK, 8'hFF);
        send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_BYTE, 8'hA5);
        send_beat(OP_BYTE, SYNC_11B);
        send_channel_word(1'b1, 4'd0, 11'd2047);
        send_channel_word(1'b1, 4'd11, 11'd0);
        send_channel_word(1'b1, 4'd15, 11'd1234);
        send_channel_word(1'b1, 4'd12, 11'd7);
        send_channel_word(1'b1, 4'd5, 11'd1024);
        send_channel_word(1'b1, 4'd0, 11'd10);   // exactly at the floor: still good
        send_channel_word(1'b1, 4'd3, 11'd555);

        // one tick now forces a resync and declares the signal lost
        drain();
        write_reg(CFG_UNUSED, 11'h7FF);
        set_config(0, 0, int'(FLOOR_RESET));
        send_beat(OP_TICK, 8'h00);

        drain();
        set_config(int'(GAP_RESET), int'(LOSS_RESET), int'(FLOOR_RESET));
        run_traffic(70, 1'b0);

        // counters wrap: no resync and no loss can happen here
        drain();
        set_config(7, 31, 0);
        run_traffic(50, 1'b0);

        drain();
        set_config(0, 1, 2047);
        run_traffic(50, 1'b0);

        drain();
        set_config(1, 0, 512);
        run_traffic(40, 1'b1);

        for (int p = 0; p < 3; p++) begin
            drain();
            set_config($urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 2047));
            run_traffic(45, 1'b0);
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("Sent %0d input beats (%0d complete frames) across %0d register settings;",
                 beats_sent, frames_sent, settings_used);
        $display("compared %0d channel result beats.", beats_checked);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : receiver
        int stall;
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: rc_satellite_frame_decoder.f
design/rcfd_pkg.sv
design/rcfd_stage_mem.sv
design/rc_satellite_frame_decoder.sv
design/rcfd_checker.sv
bench/rcfd_channel_checker.sv
bench/tb.sv
